@@ rtl/tkim_pkg.sv @@
// Package for the tick keyed interval map: request and response words,
// request and status codes, and the sequencer state types. No dependencies.
`default_nettype none
package tkim_pkg;

	localparam int CAPACITY_DEF = 16;
	localparam int KEY_W        = 32;
	localparam int CODE_W       = 16;
	localparam int ENTRY_W      = KEY_W + CODE_W;

	// Request codes.
	localparam logic [2:0] REQ_LOOKUP = 3'd0;
	localparam logic [2:0] REQ_SET    = 3'd1;
	localparam logic [2:0] REQ_REMOVE = 3'd2;
	localparam logic [2:0] REQ_EXISTS = 3'd3;
	localparam logic [2:0] REQ_MOVE   = 3'd4;
	localparam logic [2:0] REQ_RANGE  = 3'd5;

	// Status codes.
	localparam logic [1:0] STAT_OK   = 2'd0;
	localparam logic [1:0] STAT_FULL = 2'd1;
	localparam logic [1:0] STAT_NEG  = 2'd2;

	typedef struct packed {
		logic [2:0]         req_type;
		logic signed [31:0] tick;
		logic signed [31:0] dest_tick;
		logic [15:0]        type_code;
	} req_t;

	typedef struct packed {
		logic [15:0]        result_code;
		logic               found;
		logic signed [31:0] range_start;
		logic signed [31:0] range_end;
		logic [1:0]         status;
	} rsp_t;

	// Classification made by the front end.
	typedef struct packed {
		logic reject;
		logic unused;
		logic zero;
	} cls_t;

	typedef struct packed {
		req_t req;
		cls_t cls;
	} qitem_t;

	typedef enum logic [2:0] {
		S_IDLE, S_RD, S_CMP, S_DECIDE, S_SHR, S_SHW, S_SETGO, S_OUT
	} state_t;

	typedef enum logic [2:0] {
		PH_LOOKUP, PH_EXISTS, PH_RANGE, PH_SET, PH_REMOVE
	} phase_t;

endpackage
`default_nettype wire

@@ rtl/tkim_ram.sv @@
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`default_nettype none
module tkim_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule
`default_nettype wire

@@ rtl/tkim_fifo.sv @@
// Two entry queue of raw words, used between the front end and the
// sequencer and in front of the result port. No dependencies.
`default_nettype none
module tkim_fifo #(
	parameter int WIDTH = 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	output logic                  full,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      rdata,
	output logic                  empty
);
	logic [WIDTH-1:0] mem_q [2];
	logic             wr_ptr_q, rd_ptr_q;
	logic [1:0]       cnt_q;
	logic             do_push, do_pop;

	assign full    = (cnt_q == 2'd2);
	assign empty   = (cnt_q == 2'd0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end

	// Storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end
endmodule
`default_nettype wire

@@ rtl/tkim_front.sv @@
// Front end: takes request words, classifies them and queues them for the
// sequencer. Depends on tkim_pkg and tkim_fifo.
`default_nettype none
module tkim_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire tkim_pkg::req_t  req,
	output logic                 full,
	input  wire logic            q_pop,
	output tkim_pkg::qitem_t     q_item,
	output logic                 q_empty
);
	import tkim_pkg::*;

	qitem_t in_item;
	logic   is_mut;

	// A mutating request with a negative tick, or a move with a negative destination tick, is rejected outright.
	always_comb begin
		is_mut = (req.req_type == REQ_SET) || (req.req_type == REQ_REMOVE) ||
		         (req.req_type == REQ_MOVE);
		in_item.req        = req;
		in_item.cls.reject = (is_mut && req.tick < 0) ||
		                     (req.req_type == REQ_MOVE && req.dest_tick < 0);
		in_item.cls.unused = (req.req_type > REQ_RANGE);
		in_item.cls.zero   = (req.tick == 32'sd0);
	end

	tkim_fifo #(.WIDTH($bits(qitem_t))) u_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata (in_item),
		.full  (full),
		.pop   (q_pop),
		.rdata (q_item),
		.empty (q_empty)
	);
endmodule
`default_nettype wire

@@ rtl/tkim_back.sv @@
// Back end sequencer: scans the sorted change table, shifts entries on
// insert and delete, and builds one response word per request.
// Depends on tkim_pkg and tkim_ram.
`default_nettype none
module tkim_back #(
	parameter int CAPACITY = tkim_pkg::CAPACITY_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic [15:0]      cfg_wdata,
	input  wire logic             q_empty,
	input  wire tkim_pkg::qitem_t q_item,
	output logic                  q_pop,
	input  wire logic             o_full,
	output logic                  o_push,
	output tkim_pkg::rsp_t        o_rsp
);
	import tkim_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

	state_t             state_q, state_d;
	phase_t             phase_q;
	logic               move_q;
	logic signed [31:0] key_q, dest_q, prev_key_q, next_key_q;
	logic [CODE_W-1:0]  code_q, base_q, dflt_q, prev_code_q;
	logic [CW-1:0]      idx_q, count_q, up_q, upm1;
	logic               has_next_q;
	rsp_t               rsp_q;

	logic               ram_we, ram_re;
	logic [AW-1:0]      ram_waddr, ram_raddr;
	logic [ENTRY_W-1:0] ram_wdata, ram_rdata;
	logic signed [31:0] rd_key;
	logic [CODE_W-1:0]  rd_code;
	logic               hit, at_cap, dir_up, shr_done;
	logic [CODE_W-1:0]  in_effect;
	rsp_t               idle_rsp;
	logic               zero_move;

	assign rd_key    = signed'(ram_rdata[ENTRY_W-1:CODE_W]);
	assign rd_code   = ram_rdata[CODE_W-1:0];
	assign upm1      = up_q - CW'(1);
	assign hit       = (up_q != '0) && (prev_key_q == key_q);
	assign at_cap    = (count_q == CW'(CAPACITY));
	assign in_effect = (up_q == '0) ? base_q : prev_code_q;
	assign dir_up    = (phase_q == PH_SET);
	assign shr_done  = dir_up ? (idx_q == up_q) : ((idx_q + CW'(1)) >= count_q);
	assign o_rsp     = rsp_q;

	tkim_ram #(.WIDTH(ENTRY_W), .DEPTH(CAPACITY)) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Response word seeded when a request is taken from the queue.
	always_comb begin
		idle_rsp  = '0;
		zero_move = !q_item.cls.reject && !q_item.cls.unused && q_item.cls.zero &&
		            (q_item.req.req_type == REQ_MOVE);
		if (q_item.cls.reject) begin
			idle_rsp.status = STAT_NEG;
		end else if (!q_item.cls.unused && q_item.cls.zero) begin
			if (q_item.req.req_type == REQ_SET) begin
				idle_rsp.result_code = q_item.req.type_code;
			end else if (q_item.req.req_type == REQ_REMOVE ||
			             q_item.req.req_type == REQ_MOVE) begin
				idle_rsp.found = 1'b1;
			end
		end
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state, handshakes and table port controls.
	always_comb begin
		state_d   = state_q;
		q_pop     = 1'b0;
		o_push    = 1'b0;
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		ram_waddr = idx_q[AW-1:0];
		ram_wdata = ram_rdata;
		ram_raddr = idx_q[AW-1:0];
		case (state_q)
			S_IDLE: begin
				if (!q_empty) begin
					q_pop = 1'b1;
					if (q_item.cls.reject || q_item.cls.unused) begin
						state_d = S_OUT;
					end else if (q_item.cls.zero &&
					             (q_item.req.req_type == REQ_SET ||
					              q_item.req.req_type == REQ_REMOVE)) begin
						state_d = S_OUT;
					end else if (q_item.cls.zero && q_item.req.req_type == REQ_MOVE) begin
						state_d = S_SETGO;
					end else begin
						state_d = S_RD;
					end
				end
			end
			S_RD: begin
				if (idx_q == count_q) begin
					state_d = S_DECIDE;
				end else begin
					ram_re  = 1'b1;
					state_d = S_CMP;
				end
			end
			S_CMP: begin
				state_d = S_RD;
			end
			S_DECIDE: begin
				case (phase_q)
					PH_SET: begin
						if (hit) begin
							ram_we    = 1'b1;
							ram_waddr = upm1[AW-1:0];
							ram_wdata = {key_q, code_q};
							state_d   = S_OUT;
						end else if (at_cap) begin
							state_d = S_OUT;
						end else begin
							state_d = S_SHR;
						end
					end
					PH_REMOVE: begin
						if (hit) begin
							state_d = S_SHR;
						end else if (move_q) begin
							state_d = S_SETGO;
						end else begin
							state_d = S_OUT;
						end
					end
					default: begin
						state_d = S_OUT;
					end
				endcase
			end
			S_SHR: begin
				if (shr_done) begin
					if (dir_up) begin
						ram_we    = 1'b1;
						ram_wdata = {key_q, code_q};
						state_d   = S_OUT;
					end else begin
						state_d = move_q ? S_SETGO : S_OUT;
					end
				end else begin
					ram_re    = 1'b1;
					ram_raddr = dir_up ? AW'(idx_q - CW'(1)) : AW'(idx_q + CW'(1));
					state_d   = S_SHW;
				end
			end
			S_SHW: begin
				ram_we  = 1'b1;
				state_d = S_SHR;
			end
			S_SETGO: begin
				state_d = (dest_q == 32'sd0) ? S_OUT : S_RD;
			end
			S_OUT: begin
				if (!o_full) begin
					o_push  = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control state: count, base code and configured default.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			base_q  <= '0;
			dflt_q  <= '0;
		end else begin
			if (cfg_we) begin
				dflt_q <= cfg_wdata;
			end
			case (state_q)
				S_IDLE: begin
					if (!q_empty && q_item.cls.zero && !q_item.cls.reject &&
					    !q_item.cls.unused) begin
						if (q_item.req.req_type == REQ_SET) begin
							base_q <= q_item.req.type_code;
						end else if (q_item.req.req_type == REQ_REMOVE ||
						             q_item.req.req_type == REQ_MOVE) begin
							base_q <= dflt_q;
						end
					end
				end
				S_SHR: begin
					if (shr_done) begin
						count_q <= dir_up ? count_q + CW'(1) : count_q - CW'(1);
					end
				end
				S_SETGO: begin
					if (dest_q == 32'sd0) begin
						base_q <= code_q;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Request datapath, scan results and response word.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				key_q      <= q_item.req.tick;
				dest_q     <= q_item.req.dest_tick;
				// A move from tick zero carries the base code.
				code_q     <= zero_move ? base_q : q_item.req.type_code;
				idx_q      <= '0;
				up_q       <= '0;
				has_next_q <= 1'b0;
				move_q     <= (q_item.req.req_type == REQ_MOVE);
				rsp_q      <= idle_rsp;
				case (q_item.req.req_type)
					REQ_LOOKUP: phase_q <= PH_LOOKUP;
					REQ_SET:    phase_q <= PH_SET;
					REQ_EXISTS: phase_q <= PH_EXISTS;
					REQ_RANGE:  phase_q <= PH_RANGE;
					default:    phase_q <= PH_REMOVE;
				endcase
			end
			S_CMP: begin
				// Keys are sorted, so the last key at or below the tick wins.
				if (rd_key <= key_q) begin
					up_q        <= idx_q + CW'(1);
					prev_key_q  <= rd_key;
					prev_code_q <= rd_code;
				end else if (!has_next_q) begin
					has_next_q <= 1'b1;
					next_key_q <= rd_key;
				end
				idx_q <= idx_q + CW'(1);
			end
			S_DECIDE: begin
				case (phase_q)
					PH_LOOKUP: begin
						rsp_q.result_code <= (key_q < 0) ? dflt_q : in_effect;
					end
					PH_EXISTS: begin
						rsp_q.found <= hit;
					end
					PH_RANGE: begin
						if (key_q < 0) begin
							rsp_q.range_start <= -32'sd1;
							rsp_q.range_end   <= -32'sd1;
						end else begin
							rsp_q.range_start <= (up_q == '0) ? 32'sd0 : prev_key_q;
							rsp_q.range_end   <= has_next_q ? next_key_q : -32'sd1;
						end
					end
					PH_SET: begin
						if (hit) begin
							rsp_q.result_code <= code_q;
						end else if (at_cap) begin
							rsp_q.status <= STAT_FULL;
						end else begin
							idx_q <= count_q;
						end
					end
					default: begin
						rsp_q.found <= hit;
						if (move_q) begin
							code_q <= in_effect;
						end
						idx_q <= upm1;
					end
				endcase
			end
			S_SHR: begin
				if (shr_done && dir_up) begin
					rsp_q.result_code <= code_q;
				end
			end
			S_SHW: begin
				idx_q <= dir_up ? idx_q - CW'(1) : idx_q + CW'(1);
			end
			S_SETGO: begin
				key_q      <= dest_q;
				phase_q    <= PH_SET;
				idx_q      <= '0;
				up_q       <= '0;
				has_next_q <= 1'b0;
				if (dest_q == 32'sd0) begin
					rsp_q.result_code <= code_q;
				end
			end
			default: begin
			end
		endcase
	end
endmodule
`default_nettype wire

@@ rtl/tick_keyed_interval_map.sv @@
// Top level of the tick keyed interval map: front end queue, sequencer and
// result queue. Depends on tkim_pkg, tkim_front, tkim_back and tkim_fifo.
//
//   channel   ports                       moves
//   request   push, full, req             one req_t word per accepted push
//   result    empty, pop, rsp             one rsp_t word per request
//   config    cfg_we, cfg_wdata           default type code, no read-back
//
// The back end scans the stored changes with serial reads of the table
// RAM, then shifts entries with one read and one write each to finish an
// insert or delete; a move runs as a remove followed by a set.
// Reset clears the count and base code; table contents need no clearing.
// Two queues let the front accept and the result wait while the back works.
`default_nettype none
module tick_keyed_interval_map #(
	parameter int CAPACITY = tkim_pkg::CAPACITY_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire tkim_pkg::req_t req,
	output logic                full,
	output logic                empty,
	input  wire logic           pop,
	output tkim_pkg::rsp_t      rsp,
	input  wire logic           cfg_we,
	input  wire logic [15:0]    cfg_wdata
);
	import tkim_pkg::*;

	qitem_t q_item;
	logic   q_empty, q_pop;
	logic   o_full, o_push;
	rsp_t   o_rsp;

	tkim_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.req    (req),
		.full   (full),
		.q_pop  (q_pop),
		.q_item (q_item),
		.q_empty(q_empty)
	);

	tkim_back #(.CAPACITY(CAPACITY)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.q_empty  (q_empty),
		.q_item   (q_item),
		.q_pop    (q_pop),
		.o_full   (o_full),
		.o_push   (o_push),
		.o_rsp    (o_rsp)
	);

	// Result queue toward the consumer.
	tkim_fifo #(.WIDTH($bits(rsp_t))) u_out (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (o_push),
		.wdata (o_rsp),
		.full  (o_full),
		.pop   (pop),
		.rdata (rsp),
		.empty (empty)
	);
endmodule
`default_nettype wire

@@ rtl/tkim_checker.sv @@
// Port level checks for the tick keyed interval map, bound to the top
// level. Depends on tkim_pkg.
`default_nettype none
module tkim_checker (
	input wire logic           clk,
	input wire logic           arst_n,
	input wire logic           empty,
	input wire logic           pop,
	input wire tkim_pkg::rsp_t rsp
);
	import tkim_pkg::*;

	// A waiting word that is not taken stays waiting.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> !empty)
		else $error("result word dropped while not popped");

	// Only the three defined status codes appear.
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (rsp.status == STAT_OK || rsp.status == STAT_FULL ||
		            rsp.status == STAT_NEG))
		else $error("undefined status code");

	// A rejected request leaves every other field clear.
	a_neg: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && rsp.status == STAT_NEG) |->
		(rsp.result_code == '0 && !rsp.found && rsp.range_start == 0 &&
		 rsp.range_end == 0))
		else $error("rejected request carries data");

	// A full table never yields a stored code.
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && rsp.status == STAT_FULL) |-> (rsp.result_code == '0))
		else $error("full table reported a code");
endmodule

bind tick_keyed_interval_map tkim_checker u_tkim_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.empty (empty),
	.pop   (pop),
	.rsp   (rsp)
);
`default_nettype wire

@@ tb/sv/tb_tick_keyed_interval_map.sv @@
// Self-checking testbench for the tick keyed interval map.
// It predicts each response word from its own model of the change table.
// Depends on tkim_pkg and the tick_keyed_interval_map top level.
`default_nettype none
module tb_tick_keyed_interval_map;
	import tkim_pkg::*;

	localparam int CAP       = 16;
	localparam int MAX_CYC   = 2000000;
	localparam int N_RANDOM  = 1630;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	req_t req = '0;
	logic full, empty;
	logic pop = 1'b0;
	rsp_t rsp;
	logic cfg_we = 1'b0;
	logic [15:0] cfg_wdata = '0;

	tick_keyed_interval_map #(.CAPACITY(CAP)) u_dut (
		.clk(clk), .arst_n(arst_n), .push(push), .req(req), .full(full),
		.empty(empty), .pop(pop), .rsp(rsp), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	// Model state of the change table.
	logic signed [31:0] map_keys[CAP];
	logic [15:0] map_codes[CAP];
	int map_count;
	logic [15:0] map_base;
	logic [15:0] map_default;

	rsp_t expected_rsp[$];
	int mismatches = 0;
	int rsp_seen = 0;
	int cycles = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	logic hold_recv = 1'b0;
	int n_sets = 0, n_full = 0, n_neg = 0;

	// Index of the first stored key above t.
	function automatic int first_above(logic signed [31:0] t);
		int i;
		i = 0;
		while (i < map_count && map_keys[i] <= t) i++;
		return i;
	endfunction

	function automatic int key_slot(logic signed [31:0] t);
		for (int i = 0; i < map_count; i++) if (map_keys[i] == t) return i;
		return -1;
	endfunction

	function automatic logic [15:0] code_at(logic signed [31:0] t);
		int i;
		if (t < 0) return map_default;
		i = first_above(t);
		return (i == 0) ? map_base : map_codes[i - 1];
	endfunction

	// Writes a change; returns the status code.
	function automatic logic [1:0] store_change(logic signed [31:0] t, logic [15:0] c);
		int f, p;
		if (t == 0) begin
			map_base = c;
			return STAT_OK;
		end
		f = key_slot(t);
		if (f >= 0) begin
			map_codes[f] = c;
			return STAT_OK;
		end
		if (map_count >= CAP) return STAT_FULL;
		p = first_above(t);
		for (int j = map_count; j > p; j--) begin
			map_keys[j] = map_keys[j - 1];
			map_codes[j] = map_codes[j - 1];
		end
		map_keys[p] = t;
		map_codes[p] = c;
		map_count++;
		return STAT_OK;
	endfunction

	function automatic logic drop_change(logic signed [31:0] t);
		int f;
		if (t == 0) begin
			map_base = map_default;
			return 1'b1;
		end
		f = key_slot(t);
		if (f < 0) return 1'b0;
		for (int j = f; j + 1 < map_count; j++) begin
			map_keys[j] = map_keys[j + 1];
			map_codes[j] = map_codes[j + 1];
		end
		map_count--;
		return 1'b1;
	endfunction

	// Computes the response word for one request and updates the model.
	function automatic rsp_t map_response(req_t r);
		rsp_t o;
		logic [15:0] carried;
		int i;
		o = '0;
		case (r.req_type)
			REQ_LOOKUP: o.result_code = code_at(r.tick);
			REQ_SET: begin
				if (r.tick < 0) o.status = STAT_NEG;
				else begin
					o.status = store_change(r.tick, r.type_code);
					if (o.status == STAT_OK) o.result_code = r.type_code;
				end
			end
			REQ_REMOVE: begin
				if (r.tick < 0) o.status = STAT_NEG;
				else o.found = drop_change(r.tick);
			end
			REQ_EXISTS: o.found = (key_slot(r.tick) >= 0);
			REQ_MOVE: begin
				if (r.tick < 0 || r.dest_tick < 0) o.status = STAT_NEG;
				else begin
					carried = code_at(r.tick);
					o.found = drop_change(r.tick);
					o.status = store_change(r.dest_tick, carried);
					if (o.status == STAT_OK) o.result_code = carried;
				end
			end
			REQ_RANGE: begin
				if (r.tick < 0) begin
					o.range_start = -1;
					o.range_end = -1;
				end else begin
					i = first_above(r.tick);
					o.range_end = (i == map_count) ? -1 : map_keys[i];
					o.range_start = (i == 0) ? 0 : map_keys[i - 1];
				end
			end
			default: ;
		endcase
		if (o.status == STAT_FULL) n_full++;
		if (o.status == STAT_NEG) n_neg++;
		if (r.req_type == REQ_SET) n_sets++;
		return o;
	endfunction

	// Accepts a word on the request side and records its expected response.
	// Push stays high after an accepted word unless the sender idles.
	task automatic send_word(req_t r, logic check_typed, rsp_t typed);
		rsp_t e;
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		req <= r;
		@(posedge clk);
		while (full) @(posedge clk);
		e = map_response(r);
		if (check_typed && e !== typed) begin
			mismatches++;
			if (mismatches <= 10)
				$display("table row mismatch: typed %h model %h", typed, e);
		end
		expected_rsp.push_back(e);
	endtask

	task automatic drain();
		push <= 1'b0;
		while (expected_rsp.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic write_default(logic [15:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		map_default = v;
	endtask

	// Ticks biased toward a small key set so that hits, shifts and a full table occur.
	function automatic logic signed [31:0] pick_tick();
		case ($urandom_range(9))
			0: return $urandom;
			1: return -$signed({1'b0, 31'($urandom_range(40))});
			2: return 0;
			3: return 32'sh7fffffff;
			default: return $urandom_range(60);
		endcase
	endfunction

	function automatic req_t random_req();
		req_t r;
		r.req_type = ($urandom_range(49) == 0) ? 3'(6 + $urandom_range(1))
			: 3'($urandom_range(5));
		r.tick = pick_tick();
		r.dest_tick = pick_tick();
		r.type_code = 16'($urandom);
		return r;
	endfunction

	// Receiver: pops at random, or holds off when asked.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (pop && !empty) begin
			rsp_seen <= rsp_seen + 1;
			if (expected_rsp.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected response word %h", rsp);
			end else begin
				if (rsp !== expected_rsp[0]) begin
					mismatches++;
					if (mismatches <= 10)
						$display("response mismatch: expected %h got %h", expected_rsp[0], rsp);
				end
				void'(expected_rsp.pop_front());
			end
		end
		pop <= !hold_recv && ($urandom_range(99) >= recv_idle_pct);
		if (cycles >= MAX_CYC) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Long receiver hold-off counted in cycles.
	task automatic stall_receiver();
		hold_recv = 1'b1;
		repeat (400) @(posedge clk);
		hold_recv = 1'b0;
	endtask

	typedef struct {
		req_t r;
		logic typed;
		rsp_t e;
	} row_t;

	row_t rows[$];

	function automatic req_t mk(logic [2:0] op, int t, int d, logic [15:0] c);
		req_t r;
		r.req_type = op;
		r.tick = t;
		r.dest_tick = d;
		r.type_code = c;
		return r;
	endfunction

	function automatic rsp_t mr(logic [15:0] c, logic f, int s, int e, logic [1:0] st);
		rsp_t o;
		o.result_code = c;
		o.found = f;
		o.range_start = s;
		o.range_end = e;
		o.status = st;
		return o;
	endfunction

	initial begin
		for (int i = 0; i < CAP; i++) begin
			map_keys[i] = 0;
			map_codes[i] = 0;
		end
		map_count = 0;
		map_default = 0;
		map_base = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table: after reset, extremes, negative ticks, every request code.
		rows.push_back('{mk(REQ_LOOKUP, 5, 0, 0), 1, mr(0, 0, 0, 0, STAT_OK)});
		rows.push_back('{mk(REQ_RANGE, 5, 0, 0), 1, mr(0, 0, 0, -1, STAT_OK)});
		rows.push_back('{mk(REQ_RANGE, -1, 0, 0), 1, mr(0, 0, -1, -1, STAT_OK)});
		rows.push_back('{mk(REQ_SET, -5, 0, 7), 1, mr(0, 0, 0, 0, STAT_NEG)});
		rows.push_back('{mk(REQ_REMOVE, 32'h80000000, 0, 0), 1, mr(0, 0, 0, 0, STAT_NEG)});
		rows.push_back('{mk(REQ_MOVE, 3, -1, 0), 1, mr(0, 0, 0, 0, STAT_NEG)});
		rows.push_back('{mk(REQ_SET, 0, 0, 16'hffff), 1, mr(16'hffff, 0, 0, 0, STAT_OK)});
		rows.push_back('{mk(REQ_SET, 32'h7fffffff, 0, 16'h1234), 0, '0});
		rows.push_back('{mk(REQ_SET, 10, 0, 16'h0001), 0, '0});
		rows.push_back('{mk(REQ_SET, 10, 0, 16'h0002), 0, '0});
		rows.push_back('{mk(REQ_LOOKUP, 32'h7fffffff, 0, 0), 0, '0});
		rows.push_back('{mk(REQ_LOOKUP, 9, 0, 0), 0, '0});
		rows.push_back('{mk(REQ_LOOKUP, -3, 0, 0), 0, '0});
		rows.push_back('{mk(REQ_EXISTS, 10, 0, 0), 0, '0});
		rows.push_back('{mk(REQ_EXISTS, 0, 0, 0), 1, mr(0, 0, 0, 0, STAT_OK)});
		rows.push_back('{mk(REQ_EXISTS, -10, 0, 0), 1, mr(0, 0, 0, 0, STAT_OK)});
		rows.push_back('{mk(REQ_RANGE, 20, 0, 0), 0, '0});
		rows.push_back('{mk(REQ_MOVE, 10, 30, 0), 0, '0});
		rows.push_back('{mk(REQ_MOVE, 0, 40, 0), 0, '0});
		rows.push_back('{mk(REQ_REMOVE, 30, 0, 0), 0, '0});
		rows.push_back('{mk(REQ_REMOVE, 31, 0, 0), 0, '0});
		rows.push_back('{mk(REQ_REMOVE, 0, 0, 0), 0, '0});
		rows.push_back('{mk(3'd6, 1, 2, 3), 1, mr(0, 0, 0, 0, STAT_OK)});
		rows.push_back('{mk(3'd7, -1, -1, 16'hffff), 1, mr(0, 0, 0, 0, STAT_OK)});

		send_idle_pct = 9;
		recv_idle_pct = 46;
		foreach (rows[k]) send_word(rows[k].r, rows[k].typed, rows[k].e);
		drain();

		// Random phases over several default codes, extremes included.
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: write_default(16'hffff);
				1: write_default(16'h0000);
				2: write_default(16'($urandom));
				default: write_default(16'h8001);
			endcase
			send_idle_pct = (ph == 0) ? 9 : (ph == 1) ? 46 : 0;
			recv_idle_pct = (ph == 0) ? 46 : (ph == 1) ? 9 : 0;
			fork
				begin
					if (ph == 2) stall_receiver();
				end
				begin
					// Fill the table with well-formed sets, then mixed requests.
					for (int n = 0; n < N_RANDOM / 4; n++) begin
						if (n < 20)
							send_word(mk(REQ_SET, 1 + $urandom_range(40), 0, 16'($urandom)),
								0, '0);
						else
							send_word(random_req(), 0, '0);
					end
				end
			join
			drain();
		end

		$display("Covered %0d responses: %0d sets, %0d full-table and %0d negative-tick rejects.",
			rsp_seen, n_sets, n_full, n_neg);
		if (mismatches == 0 && expected_rsp.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule
`default_nettype wire
